[hw/rtl/ismd_pkg.sv]
package ismd_pkg;

    localparam int MAX_FILMS    = 256;
    localparam int DAY_MINUTES  = 1440;
    localparam int MIN_PER_HOUR = 60;

    localparam int FILM_AW = (MAX_FILMS > 1) ? $clog2(MAX_FILMS) : 1;
    localparam int CNT_W   = $clog2(MAX_FILMS + 1);
    localparam int TIME_AW = $clog2(DAY_MINUTES);

    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int START_W  = 11;
    localparam int LEN_W    = 11;
    localparam int TOT_W    = 12;
    localparam int NXT_W    = 12;
    localparam int BRK_W    = 6;
    localparam int FILM_W   = START_W + LEN_W;

    localparam logic [BRK_W-1:0] BRK_RESET = BRK_W'(10);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SOLVE,
        ST_FINISH
    } t_top_state;

    typedef enum logic {
        SV_IDLE,
        SV_SCAN
    } t_solve_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
        logic [BRK_W-1:0] brk;
    } t_solve_req;

    typedef struct packed {
        logic             done;
        logic [TOT_W-1:0] total;
    } t_solve_rsp;

endpackage

[hw/rtl/ismd_if.sv]
interface ismd_film_if import ismd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [HOUR_W-1:0]   start_hour;
    logic [MINUTE_W-1:0] start_minute;
    logic [LEN_W-1:0]    film_minutes;
    logic                last_film;

    modport source (output valid, start_hour, start_minute, film_minutes, last_film,
                    input ready);
    modport sink (input valid, start_hour, start_minute, film_minutes, last_film,
                  output ready);
endinterface

interface ismd_total_if import ismd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TOT_W-1:0] total_minutes;
    logic             overflow;

    modport source (output valid, total_minutes, overflow, input ready);
    modport sink (input valid, total_minutes, overflow, output ready);
endinterface

[hw/rtl/ismd_ram.sv]
module ismd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[hw/rtl/ismd_solver.sv]
module ismd_solver import ismd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_solve_req         i_req,
    input  logic [FILM_W-1:0]  i_film_rdata,
    output logic [FILM_AW-1:0] o_film_raddr,
    output t_solve_rsp         o_rsp
);

    t_solve_state r_state, n_state;

    logic [TIME_AW-1:0] r_t;
    logic [CNT_W-1:0]   r_k;
    logic [TOT_W-1:0]   r_cur;
    logic               r_v1;
    logic               r_v2;
    logic               r_m2;
    logic               r_in2;
    logic [LEN_W-1:0]   r_len2;

    logic               issue;
    logic               step_done;
    logic               best_we;

    logic [START_W-1:0] film_start;
    logic [LEN_W-1:0]   film_len;
    logic [NXT_W-1:0]   nxt;
    logic               match;
    logic               in_range;
    logic [TOT_W-1:0]   best_rdata;
    logic [TOT_W-1:0]   rest;
    logic [TOT_W:0]     cand;

    // best total from each start minute onward
    ismd_ram #(
        .WIDTH (TOT_W),
        .DEPTH (DAY_MINUTES)
    ) u_best_ram (
        .i_clk   (i_clk),
        .i_we    (best_we),
        .i_waddr (r_t),
        .i_wdata (r_cur),
        .i_raddr (nxt[TIME_AW-1:0]),
        .o_rdata (best_rdata)
    );

    assign step_done = (r_k == i_req.count) && !r_v1 && !r_v2;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            SV_IDLE: begin
                if (i_req.start) begin
                    n_state = SV_SCAN;
                end
            end
            SV_SCAN: begin
                if (step_done && (r_t == '0)) begin
                    n_state = SV_IDLE;
                end
            end
            default: n_state = SV_IDLE;
        endcase
    end

    always_comb begin
        issue       = (r_state == SV_SCAN) && (r_k != i_req.count);
        best_we     = (r_state == SV_SCAN) && step_done;
        o_rsp.done  = best_we && (r_t == '0);
        o_rsp.total = r_cur;
    end

    assign o_film_raddr = r_k[FILM_AW-1:0];

    // stage 1: film word back from the store
    assign film_start = i_film_rdata[START_W-1:0];
    assign film_len   = i_film_rdata[FILM_W-1:START_W];
    assign nxt        = NXT_W'(film_start) + NXT_W'(film_len) + NXT_W'(i_req.brk);
    assign match      = (film_start == START_W'(r_t)) && (nxt > NXT_W'(r_t));
    assign in_range   = nxt < NXT_W'(DAY_MINUTES);

    // stage 2: best total after the film
    assign rest = r_in2 ? best_rdata : '0;
    assign cand = (TOT_W + 1)'(r_len2) + (TOT_W + 1)'(rest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SV_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_t     <= '0;
            r_k     <= '0;
            r_cur   <= '0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            if (i_req.start && (r_state == SV_IDLE)) begin
                r_t   <= TIME_AW'(DAY_MINUTES - 1);
                r_k   <= '0;
                r_cur <= '0;
            end else if (issue) begin
                r_k <= r_k + CNT_W'(1);
            end else if (best_we) begin
                r_k <= '0;
                r_t <= r_t - TIME_AW'(1);
            end
            if (r_v2 && r_m2 && (cand > {1'b0, r_cur})) begin
                r_cur <= cand[TOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m2   <= match;
        r_in2  <= in_range;
        r_len2 <= film_len;
    end

endmodule

[hw/rtl/interval_schedule_max_duration.sv]
// channel   dir  modport  word
// i_film    in   sink     start_hour, start_minute, film_minutes, last_film
// o_total   out  source   total_minutes, overflow
// i_cfg     in   -        i_cfg_we, i_cfg_data (break_minutes)
//
// a film word is taken in one cycle and written to the film store, up to 256
// films; later ones set overflow. after the last film, one pass per minute of
// the day, 1439 down to 0, scans the N stored films through the film store
// read port
// i_film.ready is low during the pass and until the result enters o_total
// films of the next set load while a result waits on o_total
// synchronous active-low reset: break 10, empty set; tables are not cleared
module interval_schedule_max_duration import ismd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ismd_film_if.sink          i_film,
    ismd_total_if.source       o_total,
    input  logic               i_cfg_we,
    input  logic [BRK_W-1:0]   i_cfg_data
);

    t_top_state r_state, n_state;

    logic [BRK_W-1:0]   r_break;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic               r_out_valid;
    logic [TOT_W-1:0]   r_out_total;
    logic               r_out_ovf;

    logic               accept;
    logic               store_we;
    logic               slot_free;
    logic               load_out;
    logic [START_W-1:0] start_min;
    logic [LEN_W-1:0]   len_sat;
    logic [FILM_AW-1:0] film_raddr;
    logic [FILM_W-1:0]  film_rdata;

    t_solve_req         req;
    t_solve_rsp         rsp;

    assign accept    = i_film.valid && i_film.ready;
    assign store_we  = accept && (r_count < CNT_W'(MAX_FILMS));
    assign slot_free = !r_out_valid || o_total.ready;

    assign start_min = START_W'(i_film.start_hour) * START_W'(MIN_PER_HOUR)
                     + START_W'(i_film.start_minute);
    assign len_sat   = (i_film.film_minutes > LEN_W'(DAY_MINUTES)) ?
                       LEN_W'(DAY_MINUTES) : i_film.film_minutes;

    ismd_ram #(
        .WIDTH (FILM_W),
        .DEPTH (MAX_FILMS)
    ) u_film_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_count[FILM_AW-1:0]),
        .i_wdata ({len_sat, start_min}),
        .i_raddr (film_raddr),
        .o_rdata (film_rdata)
    );

    ismd_solver u_solver (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_film_rdata (film_rdata),
        .o_film_raddr (film_raddr),
        .o_rsp        (rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (accept && i_film.last_film) begin
                    n_state = ST_SOLVE;
                end
            end
            ST_SOLVE: begin
                if (rsp.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        i_film.ready = (r_state == ST_LOAD);
        req.start    = accept && i_film.last_film;
        req.count    = r_count;
        req.brk      = r_break;
        load_out     = (r_state == ST_FINISH) && slot_free;
    end

    assign o_total.valid         = r_out_valid;
    assign o_total.total_minutes = r_out_total;
    assign o_total.overflow      = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_break     <= BRK_RESET;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_break <= i_cfg_data;
            end
            if (load_out) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (store_we) begin
                r_count <= r_count + CNT_W'(1);
            end else if (accept) begin
                r_ovf <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_total.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_total <= rsp.total;
            r_out_ovf   <= r_ovf;
        end
    end

endmodule
